FILE: hw/rtl/ir_pulse_distance_frame_decoder_defines.svh
// Assertion macros for the checker file of the IR frame decoder.
// Depends on nothing; include by bare file name.
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH

// Check a property outside reset.
`define IRPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("irpd assertion failed");

// Check a property at every edge, reset included.
`define IRPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("irpd assertion failed");

`endif

FILE: hw/rtl/irpd_pkg.sv
// Package of the IR pulse distance frame decoder: types, constants, button lookup.
// Depends on nothing; used by all decoder modules by scoped names.
package irpd_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BTN_W     = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned FRAME_W   = 32;

    localparam logic [CNT_W-1:0] FRAME_BITS = CNT_W'(FRAME_W);

    localparam logic [TICK_W-1:0] START_RESET = 16'd13000;
    localparam logic [TICK_W-1:0] ONE_RESET   = 16'd1600;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE   = 2'd1;

    localparam logic [BTN_W-1:0] BTN_UP      = 5'd0;
    localparam logic [BTN_W-1:0] BTN_DOWN    = 5'd1;
    localparam logic [BTN_W-1:0] BTN_LEFT    = 5'd2;
    localparam logic [BTN_W-1:0] BTN_RIGHT   = 5'd3;
    localparam logic [BTN_W-1:0] BTN_OK      = 5'd4;
    localparam logic [BTN_W-1:0] BTN_DIGIT0  = 5'd7;
    localparam logic [BTN_W-1:0] BTN_UNKNOWN = 5'd17;

    typedef struct packed {
        logic [TICK_W-1:0] start_threshold;
        logic [TICK_W-1:0] one_threshold;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] address_inverse;
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] command_inverse;
        logic [BTN_W-1:0]  button_code;
    } t_result;

    function automatic logic [BTN_W-1:0] button_of(input logic [BYTE_W-1:0] cmd);
        logic [BTN_W-1:0] code;
        unique case (cmd)
            8'h18:   code = BTN_UP;
            8'h4A:   code = BTN_DOWN;
            8'h88:   code = BTN_LEFT;
            8'hAD:   code = BTN_RIGHT;
            8'h38:   code = BTN_OK;
            8'hCC:   code = BTN_DIGIT0;
            8'hA2:   code = BTN_DIGIT0 + 5'd1;
            8'h62:   code = BTN_DIGIT0 + 5'd2;
            8'hE2:   code = BTN_DIGIT0 + 5'd3;
            8'h22:   code = BTN_DIGIT0 + 5'd4;
            8'h81:   code = BTN_DIGIT0 + 5'd5;
            8'hE1:   code = BTN_DIGIT0 + 5'd6;
            8'hE0:   code = BTN_DIGIT0 + 5'd7;
            8'hD4:   code = BTN_DIGIT0 + 5'd8;
            8'h90:   code = BTN_DIGIT0 + 5'd9;
            default: code = BTN_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

FILE: hw/rtl/irpd_cfg_regs.sv
// Threshold register file of the IR frame decoder.
// Depends on irpd_pkg.
module irpd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [irpd_pkg::TICK_W-1:0]      i_cfg_data,
    output irpd_pkg::t_cfg                   o_cfg
);

    irpd_pkg::t_cfg r_cfg;
    irpd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                irpd_pkg::CFG_START: n_cfg.start_threshold = i_cfg_data;
                irpd_pkg::CFG_ONE:   n_cfg.one_threshold   = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_threshold <= irpd_pkg::START_RESET;
            r_cfg.one_threshold   <= irpd_pkg::ONE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/irpd_in_stage.sv
// Input register of the IR frame decoder: holds one interval item for the core.
// Depends on irpd_pkg.
module irpd_in_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [irpd_pkg::TICK_W-1:0]  i_in_interval_ticks,
    output logic                         o_in_stall,
    input  logic                         i_advance,
    output logic                         o_item_valid,
    output logic [irpd_pkg::TICK_W-1:0]  o_item_ticks
);

    logic                        r_valid;
    logic                        n_valid;
    logic [irpd_pkg::TICK_W-1:0] r_ticks;
    logic                        take;

    // Stall only while a held item cannot move into the core.
    assign o_in_stall = r_valid && !i_advance;
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        if (take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ticks <= i_in_interval_ticks;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item_ticks = r_ticks;

endmodule

FILE: hw/rtl/irpd_frame_core.sv
// Frame decoding core: leader hunt, bit shifting, button lookup, result register.
// Depends on irpd_pkg.
module irpd_frame_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  irpd_pkg::t_cfg               i_cfg,
    input  logic                         i_item_valid,
    input  logic [irpd_pkg::TICK_W-1:0]  i_item_ticks,
    output logic                         o_advance,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output irpd_pkg::t_result            o_result
);

    logic                          r_receiving;
    logic                          n_receiving;
    logic                          r_pair_phase;
    logic                          n_pair_phase;
    logic [irpd_pkg::CNT_W-1:0]    r_bit_count;
    logic [irpd_pkg::CNT_W-1:0]    n_bit_count;
    logic [irpd_pkg::FRAME_W-1:0]  r_frame_shift;
    logic [irpd_pkg::FRAME_W-1:0]  n_frame_shift;
    logic                          r_out_valid;
    logic                          n_out_valid;
    irpd_pkg::t_result             r_result;
    irpd_pkg::t_result             n_result;
    logic                          step;
    logic                          done;
    logic [irpd_pkg::CNT_W-1:0]    count_inc;

    // The result register is free, or its item leaves this cycle.
    assign o_advance = !r_out_valid || !i_out_stall;
    assign step      = i_item_valid && o_advance;
    assign count_inc = r_bit_count + irpd_pkg::CNT_W'(1);

    always_comb begin
        n_receiving   = r_receiving;
        n_pair_phase  = r_pair_phase;
        n_bit_count   = r_bit_count;
        n_frame_shift = r_frame_shift;
        done          = 1'b0;
        if (step) begin
            if (!r_receiving) begin
                n_pair_phase = !r_pair_phase;
                if (r_pair_phase && (i_item_ticks > i_cfg.start_threshold)) begin
                    n_receiving   = 1'b1;
                    n_bit_count   = '0;
                    n_frame_shift = '0;
                end
            end else begin
                n_frame_shift = {r_frame_shift[irpd_pkg::FRAME_W-2:0],
                                 (i_item_ticks > i_cfg.one_threshold)};
                n_bit_count   = count_inc;
                if (count_inc == irpd_pkg::FRAME_BITS) begin
                    done         = 1'b1;
                    n_receiving  = 1'b0;
                    n_pair_phase = 1'b0;
                    n_bit_count  = '0;
                end
            end
        end
    end

    always_comb begin
        n_result.address_byte    = n_frame_shift[31:24];
        n_result.address_inverse = n_frame_shift[23:16];
        n_result.command_byte    = n_frame_shift[15:8];
        n_result.command_inverse = n_frame_shift[7:0];
        n_result.button_code     = irpd_pkg::button_of(n_frame_shift[15:8]);
        n_out_valid              = done || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving   <= 1'b0;
            r_pair_phase  <= 1'b0;
            r_bit_count   <= '0;
            r_frame_shift <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_receiving   <= n_receiving;
            r_pair_phase  <= n_pair_phase;
            r_bit_count   <= n_bit_count;
            r_frame_shift <= n_frame_shift;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: hw/rtl/ir_pulse_distance_frame_decoder.sv
// Top level of the IR pulse distance frame decoder.
// Depends on irpd_pkg, irpd_cfg_regs, irpd_in_stage and irpd_frame_core.
//
// Usage:
//   Input channel: one item per falling-edge interval (i_in_interval_ticks),
//   handed over on i_in_valid while o_in_stall is low.
//   Output channel: one item per complete frame, with the four frame bytes
//   and the button code, held on o_out_* while o_out_valid is high and taken
//   at an edge where i_out_stall is low.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 start threshold, 1 bit threshold); other indexes are ignored.
//   Write only while the block is idle.
// Timing: an interval is held in the input register, then the core decodes it;
//   the result register and o_out_valid are loaded at the edge at which the
//   core takes the 32nd data bit from the input register.
// Throughput: one item per cycle while no result waits under i_out_stall,
//   set by the single decode step between the input and result registers.
// Reset: synchronous, active low; thresholds return to 13000 and 1600, the
//   decoder hunts for a leader with the pair phase cleared, no item is held.
// Stall: while a result waits under i_out_stall, the core stops; the input
//   register takes at most one more item and then o_in_stall rises.
module ir_pulse_distance_frame_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [irpd_pkg::TICK_W-1:0]    i_in_interval_ticks,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [irpd_pkg::BYTE_W-1:0]    o_out_address_byte,
    output logic [irpd_pkg::BYTE_W-1:0]    o_out_address_inverse,
    output logic [irpd_pkg::BYTE_W-1:0]    o_out_command_byte,
    output logic [irpd_pkg::BYTE_W-1:0]    o_out_command_inverse,
    output logic [irpd_pkg::BTN_W-1:0]     o_out_button_code,
    input  logic                           i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irpd_pkg::TICK_W-1:0]    i_cfg_data
);

    irpd_pkg::t_cfg              cfg;
    irpd_pkg::t_result           result;
    logic                        advance;
    logic                        item_valid;
    logic [irpd_pkg::TICK_W-1:0] item_ticks;

    // Threshold registers.
    irpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Hold the incoming item until the core takes it.
    irpd_in_stage u_in (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_interval_ticks (i_in_interval_ticks),
        .o_in_stall          (o_in_stall),
        .i_advance           (advance),
        .o_item_valid        (item_valid),
        .o_item_ticks        (item_ticks)
    );

    // Decode intervals and register the finished frame.
    irpd_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item_ticks (item_ticks),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    // Split the result item onto its field ports.
    assign o_out_address_byte    = result.address_byte;
    assign o_out_address_inverse = result.address_inverse;
    assign o_out_command_byte    = result.command_byte;
    assign o_out_command_inverse = result.command_inverse;
    assign o_out_button_code     = result.button_code;

endmodule

FILE: hw/rtl/irpd_checker.sv
// Port-level checker of the IR frame decoder, bound to the top level.
// Depends on irpd_pkg and ir_pulse_distance_frame_decoder_defines.svh.
`include "ir_pulse_distance_frame_decoder_defines.svh"

module irpd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [irpd_pkg::BYTE_W-1:0] o_out_address_byte,
    input  logic [irpd_pkg::BYTE_W-1:0] o_out_command_byte,
    input  logic [irpd_pkg::BTN_W-1:0]  o_out_button_code
);

    // Input backs up only behind a stalled result.
    `IRPD_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall))
    // Reset drops any pending result.
    `IRPD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)
    // A stalled result stays offered.
    `IRPD_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid)
    // A stalled result keeps its payload.
    `IRPD_ASSERT(a_out_stable, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> ($stable(o_out_address_byte) && $stable(o_out_command_byte) && $stable(o_out_button_code)))

endmodule

bind ir_pulse_distance_frame_decoder irpd_checker u_irpd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_out_address_byte (o_out_address_byte),
    .o_out_command_byte (o_out_command_byte),
    .o_out_button_code  (o_out_button_code)
);

FILE: bench/ir_pulse_distance_frame_decoder_tb.sv
// Self-checking bench for the IR pulse distance frame decoder: drives edge intervals,
// predicts each decoded frame and compares every result field by field.
// Depends on irpd_pkg and the ir_pulse_distance_frame_decoder RTL.
`timescale 1ns / 1ps

module ir_pulse_distance_frame_decoder_tb;

    import irpd_pkg::*;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Command bytes of the remote, in button code order: up, down, left, right, ok,
    // then digits 0..9.
    localparam logic [39:0] NAV_CMDS   = {8'h18, 8'h4A, 8'h88, 8'hAD, 8'h38};
    localparam logic [79:0] DIGIT_CMDS = {8'hCC, 8'hA2, 8'h62, 8'hE2, 8'h22,
                                          8'h81, 8'hE1, 8'hE0, 8'hD4, 8'h90};

    localparam int unsigned TICK_MAX       = 65535;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          HOLDOFF_CYCLES = 300;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [TICK_W-1:0]    in_ticks    = '0;
    logic                 out_stall   = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [TICK_W-1:0]    cfg_data    = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [BYTE_W-1:0]    o_out_address_byte;
    logic [BYTE_W-1:0]    o_out_address_inverse;
    logic [BYTE_W-1:0]    o_out_command_byte;
    logic [BYTE_W-1:0]    o_out_command_inverse;
    logic [BTN_W-1:0]     o_out_button_code;

    // Shadow of the decoder: thresholds, hunt/receive state and the bit shifter.
    logic [TICK_W-1:0]    thr_start  = START_RESET;
    logic [TICK_W-1:0]    thr_one    = ONE_RESET;
    logic                 rx_active  = 1'b0;
    logic                 pair_odd   = 1'b0;
    logic [CNT_W-1:0]     bit_cnt    = '0;
    logic [FRAME_W-1:0]   frame_bits = '0;

    // Frames decoded by the shadow and not yet seen on the output.
    t_result pending_frames[$];

    int failures        = 0;
    int items_accepted  = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int holdoff_cycles  = 0;

    always #2 clk = ~clk;

    ir_pulse_distance_frame_decoder uut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (o_in_stall),
        .i_in_interval_ticks   (in_ticks),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .o_out_address_byte    (o_out_address_byte),
        .o_out_address_inverse (o_out_address_inverse),
        .o_out_command_byte    (o_out_command_byte),
        .o_out_command_inverse (o_out_command_inverse),
        .o_out_button_code     (o_out_button_code),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_index),
        .i_cfg_data            (cfg_data)
    );

    // Map a command byte to its button; anything off the table is unknown.
    function automatic logic [BTN_W-1:0] key_for_command(input logic [BYTE_W-1:0] cmd);
        logic [BTN_W-1:0] code;
        code = BTN_UNKNOWN;
        for (int n = 0; n < 5; n++)
            if (NAV_CMDS[39-8*n -: 8] == cmd) code = BTN_UP + BTN_W'(n);
        for (int d = 0; d < 10; d++)
            if (DIGIT_CMDS[79-8*d -: 8] == cmd) code = BTN_DIGIT0 + BTN_W'(d);
        return code;
    endfunction

    // Advance the shadow decoder by one accepted interval; queue a frame when the
    // 32nd data bit lands.
    function automatic void decode_interval(input logic [TICK_W-1:0] iv);
        t_result frame;
        if (!rx_active) begin
            // Hunting: the first of a pair is dropped, the second must beat the
            // start threshold strictly.
            if (!pair_odd) begin
                pair_odd = 1'b1;
            end else begin
                pair_odd = 1'b0;
                if (iv > thr_start) begin
                    rx_active  = 1'b1;
                    bit_cnt    = '0;
                    frame_bits = '0;
                end
            end
        end else begin
            frame_bits = {frame_bits[FRAME_W-2:0], iv > thr_one};
            bit_cnt    = bit_cnt + 1'b1;
            if (bit_cnt == FRAME_BITS) begin
                // Complements go out as received, never checked.
                frame.address_byte    = frame_bits[31:24];
                frame.address_inverse = frame_bits[23:16];
                frame.command_byte    = frame_bits[15:8];
                frame.command_inverse = frame_bits[7:0];
                frame.button_code     = key_for_command(frame_bits[15:8]);
                pending_frames.push_back(frame);
                rx_active = 1'b0;
                pair_odd  = 1'b0;
                bit_cnt   = '0;
            end
        end
    endfunction

    // Pick an interval that decodes to bit b. Boundary mode alternates between the
    // exact threshold values and the extremes of the field.
    function automatic logic [TICK_W-1:0] bit_interval(input logic b, input bit boundary,
                                                       input int pos);
        if (b && thr_one == '1) return '1;   // no interval can exceed the max
        if (boundary) begin
            if (b) return pos[0] ? '1 : thr_one + 1'b1;
            return pos[0] ? '0 : thr_one;
        end
        if (b) return TICK_W'($urandom_range(TICK_MAX, thr_one + 1));
        return TICK_W'($urandom_range(thr_one, 0));
    endfunction

    // Random frame: mostly real commands and proper complements, sometimes not.
    function automatic logic [FRAME_W-1:0] random_frame_word();
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] addr_inv;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] cmd_inv;
        int                k;
        addr = BYTE_W'($urandom());
        k    = $urandom_range(14);
        if ($urandom_range(99) < 65)
            cmd = (k < 5) ? NAV_CMDS[39-8*k -: 8] : DIGIT_CMDS[79-8*(k-5) -: 8];
        else
            cmd = BYTE_W'($urandom());
        addr_inv = ($urandom_range(9) < 8) ? ~addr : BYTE_W'($urandom());
        cmd_inv  = ($urandom_range(9) < 8) ? ~cmd  : BYTE_W'($urandom());
        return {addr, addr_inv, cmd, cmd_inv};
    endfunction

    // Offer one interval, with random idle cycles ahead of it; hold the payload
    // until the block takes it, then update the shadow.
    task automatic send_interval(input logic [TICK_W-1:0] iv);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_ticks <= iv;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        decode_interval(iv);
        items_accepted++;
    endtask

    // Send a leader pair (unless a frame is already open) and n_bits data bits of
    // word, MSB first. Fewer than 32 bits leaves a broken frame behind.
    task automatic send_frame(input logic [FRAME_W-1:0] word, input int n_bits,
                              input bit boundary);
        if (!rx_active) begin
            // Realign so the dropped slot of the pair comes first.
            if (pair_odd) send_interval(TICK_W'($urandom_range(thr_start, 0)));
            send_interval(TICK_W'($urandom()));
            send_interval(thr_start == '1 ? '1
                                          : TICK_W'($urandom_range(TICK_MAX, thr_start + 1)));
        end
        for (int i = 0; i < n_bits; i++)
            send_interval(bit_interval(word[FRAME_W-1-i], boundary, i));
    endtask

    // Write one register; only call while nothing is in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_START)
            thr_start = value;
        else if (idx == CFG_ONE)
            thr_one = value;
    endtask

    // Drop valid, wait for every queued frame, then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Reset thresholds: equal start value is no leader, then two frames with
    // boundary bit intervals, a bad complement and an unknown command; the second
    // leader follows the first frame at once to check the pair phase is cleared.
    task automatic test_directed_frames();
        send_interval(16'd12345);
        send_interval(START_RESET);
        send_interval(16'h0000);
        send_interval(16'hFFFF);
        send_frame({8'hFF, 8'h00, 8'h18, 8'h18}, FRAME_W, 1'b1);
        send_interval(16'd7);
        send_interval(START_RESET + 1'b1);
        send_frame({8'h5A, 8'hA5, 8'h00, 8'h37}, FRAME_W, 1'b1);
        wait_idle();
    endtask

    // Writes past the register map must not touch either threshold.
    task automatic test_spare_registers();
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        send_frame({8'h00, 8'hFF, 8'h90, 8'h6F}, FRAME_W, 1'b0);
        send_frame(random_frame_word(), FRAME_W, 1'b1);
        wait_idle();
    endtask

    // Threshold extremes: max start never finds a leader, zero start needs a
    // nonzero interval, max bit threshold gives all zeros, zero gives ones on any
    // nonzero interval.
    task automatic test_threshold_extremes();
        write_reg(CFG_START, '1);
        send_interval(16'hFFFF);
        send_interval(16'hFFFF);
        send_interval(16'h0000);
        send_interval(16'hFFFF);
        send_interval(16'd1234);
        send_interval(16'hFFFF);
        wait_idle();
        write_reg(CFG_START, '0);
        write_reg(CFG_ONE, '1);
        send_interval(16'd9);
        send_interval(16'd0);
        send_frame(random_frame_word(), FRAME_W, 1'b0);
        wait_idle();
        write_reg(CFG_ONE, '0);
        send_frame(random_frame_word(), FRAME_W, 1'b1);
        wait_idle();
    endtask

    // Hold the receiver off across a finished frame while intervals keep coming,
    // so the core parks and the input side has to stall.
    task automatic test_input_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        write_reg(CFG_START, START_RESET);
        write_reg(CFG_ONE, ONE_RESET);
        send_frame(random_frame_word(), FRAME_W - 1, 1'b0);
        holdoff_cycles = HOLDOFF_CYCLES;
        send_interval(bit_interval(1'($urandom_range(1)), 1'b0, 0));
        repeat (2) send_frame(random_frame_word(), FRAME_W, 1'b0);
        wait_idle();
    endtask

    // Random traffic under one threshold setting and one idling pattern: mostly
    // complete frames, some noise bursts and truncated frames.
    task automatic test_traffic(input int idle_pct, input int stall_pct,
                                input logic [TICK_W-1:0] start_thr,
                                input logic [TICK_W-1:0] one_thr, input int n_items);
        int target;
        int n_bits;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        write_reg(CFG_START, start_thr);
        write_reg(CFG_ONE, one_thr);
        target = items_accepted + n_items;
        while (items_accepted < target) begin
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(4, 1)) send_interval(TICK_W'($urandom()));
            n_bits = ($urandom_range(9) == 0) ? int'($urandom_range(FRAME_W - 1, 1)) : FRAME_W;
            send_frame(random_frame_word(), n_bits, $urandom_range(7) == 0);
        end
        wait_idle();
    endtask

    // Receiver: a counted hold-off wins over the random stall pattern.
    always @(posedge clk) begin
        if (holdoff_cycles > 0) begin
            holdoff_cycles = holdoff_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic int field_bad(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Compare each taken result with the oldest predicted frame.
    always @(posedge clk) begin : frame_checker
        t_result want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_frames.size() == 0) begin
                $error("frame result with nothing expected");
                failures++;
            end else begin
                want = pending_frames.pop_front();
                failures += field_bad("address_byte", want.address_byte, o_out_address_byte);
                failures += field_bad("address_inverse", want.address_inverse,
                                      o_out_address_inverse);
                failures += field_bad("command_byte", want.command_byte, o_out_command_byte);
                failures += field_bad("command_inverse", want.command_inverse,
                                      o_out_command_inverse);
                failures += field_bad("button_code", 8'(want.button_code),
                                      8'(o_out_button_code));
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_spare_registers();
        test_threshold_extremes();
        test_input_backpressure();
        test_traffic(0, 0, START_RESET, ONE_RESET, 370);
        test_traffic(56, 0, 16'd9000, 16'd1125, 350);
        test_traffic(0, 56, 16'd40000, 16'd30000, 350);
        test_traffic(12, 12, TICK_W'($urandom_range(TICK_MAX - 1)), TICK_W'($urandom()), 370);

        wait_idle();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_cfg_regs.sv
hw/rtl/irpd_in_stage.sv
hw/rtl/irpd_frame_core.sv
hw/rtl/ir_pulse_distance_frame_decoder.sv
hw/rtl/irpd_checker.sv
bench/ir_pulse_distance_frame_decoder_tb.sv
